>>> sv/gfpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfpe_pkg
// shared constants, types and field arithmetic for the sparse polynomial
// evaluator over GF(2^n)
// ----------------------------------------------------------------------------
package gfpe_pkg;

    localparam int FIELD_BITS = 8;
    localparam int MAX_TERMS  = 3;
    localparam int POW_BITS   = 8;
    localparam int MOD_BITS   = FIELD_BITS + 1;
    localparam int CNT_BITS   = 2;
    localparam int CFG_DATA_BITS = (MOD_BITS > POW_BITS) ? MOD_BITS : POW_BITS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int DATA_BITS  = ((2 * FIELD_BITS + 7) / 8) * 8;

    localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(283);

    typedef logic [FIELD_BITS-1:0] t_elem;
    typedef logic [POW_BITS-1:0]   t_pow;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FIELD_MODULUS = 3'd0,
        CFG_TERM_COUNT    = 3'd1,
        CFG_COEFF_ZERO    = 3'd2,
        CFG_POWER_ZERO    = 3'd3,
        CFG_COEFF_ONE     = 3'd4,
        CFG_POWER_ONE     = 3'd5,
        CFG_COEFF_TWO     = 3'd6,
        CFG_POWER_TWO     = 3'd7
    } t_cfg_reg;

    localparam t_cfg_reg COEFF_IDX [3] = '{CFG_COEFF_ZERO, CFG_COEFF_ONE, CFG_COEFF_TWO};
    localparam t_cfg_reg POWER_IDX [3] = '{CFG_POWER_ZERO, CFG_POWER_ONE, CFG_POWER_TWO};

    // per term, one running power for x and one for x xor a
    typedef logic [MAX_TERMS-1:0][1:0][FIELD_BITS-1:0] t_acc;

    typedef struct packed {
        t_elem x;
        t_elem xa;
        t_acc  r;
    } t_lane;

    typedef struct packed {
        t_elem                              taps;
        logic [CNT_BITS-1:0]                count;
        logic [MAX_TERMS-1:0][FIELD_BITS-1:0] coeff;
        logic [MAX_TERMS-1:0][POW_BITS-1:0]   power;
    } t_cfg;

    // shift-and-add product, reduced by the low taps of the modulus
    function automatic t_elem gf_mul(t_elem a, t_elem b, t_elem taps);
        t_elem acc;
        t_elem s;
        acc = '0;
        s   = a;
        for (int i = 0; i < FIELD_BITS; i++) begin
            if (b[i]) begin
                acc = acc ^ s;
            end
            s = {s[FIELD_BITS-2:0], 1'b0} ^ (s[FIELD_BITS-1] ? taps : '0);
        end
        return acc;
    endfunction

endpackage

>>> sv/gf2n_poly_eval_derivative_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2n_poly_eval_derivative_core
// evaluates a sparse polynomial over GF(2^n) at x and at x xor a per beat
// ----------------------------------------------------------------------------
// pipeline: two stages per exponent bit in the cell row, one coefficient stage,
//   one output register
// throughput: one beat per cycle while the output is not stalled, set by the fully pipelined cell row
// reset: synchronous active low; empties the pipeline, restores the registers
//   (modulus 283, no terms in use)
module gf2n_poly_eval_derivative_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // point, difference
    input  logic [gfpe_pkg::DATA_BITS-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // value_at_point, derivative_value
    output logic [gfpe_pkg::DATA_BITS-1:0]      m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gfpe_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [gfpe_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int NCELLS = gfpe_pkg::POW_BITS;

    gfpe_pkg::t_cfg  r_cfg;
    gfpe_pkg::t_cfg  n_cfg;
    logic            w_en;
    gfpe_pkg::t_lane w_head;
    logic            w_valid [NCELLS+1];
    gfpe_pkg::t_lane w_data  [NCELLS+1];
    logic [NCELLS-1:0] w_cell_valid;
    gfpe_pkg::t_elem w_value;
    gfpe_pkg::t_elem w_deriv;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                gfpe_pkg::CFG_FIELD_MODULUS: begin
                    n_cfg.taps = i_cfg_data[gfpe_pkg::FIELD_BITS-1:0];
                end
                gfpe_pkg::CFG_TERM_COUNT: begin
                    n_cfg.count = i_cfg_data[gfpe_pkg::CNT_BITS-1:0];
                end
                default: begin
                end
            endcase
            for (int k = 0; k < gfpe_pkg::MAX_TERMS; k++) begin
                if (i_cfg_index == gfpe_pkg::COEFF_IDX[k]) begin
                    n_cfg.coeff[k] = i_cfg_data[gfpe_pkg::FIELD_BITS-1:0];
                end
                if (i_cfg_index == gfpe_pkg::POWER_IDX[k]) begin
                    n_cfg.power[k] = i_cfg_data[gfpe_pkg::POW_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.taps  <= gfpe_pkg::MODULUS_RESET[gfpe_pkg::FIELD_BITS-1:0];
            r_cfg.count <= '0;
            r_cfg.coeff <= '0;
            r_cfg.power <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // whole row advances unless a finished beat is stuck at the output
    assign w_en          = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = w_en;

    always_comb begin
        w_head.x  = s_axis_tdata[gfpe_pkg::FIELD_BITS-1:0];
        w_head.xa = s_axis_tdata[gfpe_pkg::FIELD_BITS-1:0]
                  ^ s_axis_tdata[2*gfpe_pkg::FIELD_BITS-1:gfpe_pkg::FIELD_BITS];
        for (int k = 0; k < gfpe_pkg::MAX_TERMS; k++) begin
            w_head.r[k][0] = gfpe_pkg::t_elem'(1);
            w_head.r[k][1] = gfpe_pkg::t_elem'(1);
        end
    end

    assign w_valid[0] = s_axis_tvalid;
    assign w_data[0]  = w_head;

    // msb of the exponent is handled by the first cell
    for (genvar c = 0; c < NCELLS; c++) begin : g_cell
        logic [gfpe_pkg::MAX_TERMS-1:0] w_bits;
        for (genvar k = 0; k < gfpe_pkg::MAX_TERMS; k++) begin : g_bit
            assign w_bits[k] = r_cfg.power[k][NCELLS-1-c];
        end
        gfpe_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[c]),
            .i_data  (w_data[c]),
            .i_bits  (w_bits),
            .i_taps  (r_cfg.taps),
            .o_valid (w_valid[c+1]),
            .o_data  (w_data[c+1])
        );
        assign w_cell_valid[c] = w_valid[c+1];
    end

    gfpe_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_valid[NCELLS]),
        .i_data  (w_data[NCELLS]),
        .i_cfg   (r_cfg),
        .o_valid (m_axis_tvalid),
        .o_value (w_value),
        .o_deriv (w_deriv)
    );

    assign m_axis_tdata = gfpe_pkg::DATA_BITS'({w_deriv, w_value});

`ifndef ASSERT_OFF
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 w_en |=> w_cell_valid[0])
        else $error("accepted beat lost");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(w_cell_valid))
        else $error("cell row moved during output stall");

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (m_axis_tready || !m_axis_tvalid))
        else $error("input ready not tied to output register state");
`endif

endmodule

>>> sv/gfpe_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfpe_cell
// one exponent bit of square-and-multiply for every term and both points:
// a squaring stage followed by a conditional multiply stage
// ----------------------------------------------------------------------------
module gfpe_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  gfpe_pkg::t_lane                  i_data,
    input  logic [gfpe_pkg::MAX_TERMS-1:0]   i_bits,
    input  gfpe_pkg::t_elem                  i_taps,
    output logic                             o_valid,
    output gfpe_pkg::t_lane                  o_data
);

    logic            r_sq_valid;
    gfpe_pkg::t_lane r_sq_data;
    gfpe_pkg::t_lane n_sq_data;
    logic            r_mul_valid;
    gfpe_pkg::t_lane r_mul_data;
    gfpe_pkg::t_lane n_mul_data;

    always_comb begin
        n_sq_data = i_data;
        for (int k = 0; k < gfpe_pkg::MAX_TERMS; k++) begin
            for (int p = 0; p < 2; p++) begin
                n_sq_data.r[k][p] = gfpe_pkg::gf_mul(i_data.r[k][p], i_data.r[k][p], i_taps);
            end
        end
    end

    always_comb begin
        n_mul_data = r_sq_data;
        for (int k = 0; k < gfpe_pkg::MAX_TERMS; k++) begin
            if (i_bits[k]) begin
                n_mul_data.r[k][0] = gfpe_pkg::gf_mul(r_sq_data.r[k][0], r_sq_data.x, i_taps);
                n_mul_data.r[k][1] = gfpe_pkg::gf_mul(r_sq_data.r[k][1], r_sq_data.xa, i_taps);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid  <= 1'b0;
            r_mul_valid <= 1'b0;
        end else if (i_en) begin
            r_sq_valid  <= i_valid;
            r_mul_valid <= r_sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_data  <= n_sq_data;
            r_mul_data <= n_mul_data;
        end
    end

    assign o_valid = r_mul_valid;
    assign o_data  = r_mul_data;

endmodule

>>> sv/gfpe_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfpe_sum
// scales each term's power by its coefficient, then folds the active terms
// into F(x) and the derivative in the output register
// ----------------------------------------------------------------------------
module gfpe_sum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  gfpe_pkg::t_lane i_data,
    input  gfpe_pkg::t_cfg  i_cfg,
    output logic            o_valid,
    output gfpe_pkg::t_elem o_value,
    output gfpe_pkg::t_elem o_deriv
);

    logic            r_prod_valid;
    gfpe_pkg::t_acc  r_prod;
    gfpe_pkg::t_acc  n_prod;
    logic            r_out_valid;
    gfpe_pkg::t_elem r_value;
    gfpe_pkg::t_elem r_deriv;
    gfpe_pkg::t_elem n_value;
    gfpe_pkg::t_elem n_deriv;

    always_comb begin
        for (int k = 0; k < gfpe_pkg::MAX_TERMS; k++) begin
            for (int p = 0; p < 2; p++) begin
                // terms past the count contribute nothing
                if (gfpe_pkg::CNT_BITS'(k) < i_cfg.count) begin
                    n_prod[k][p] = gfpe_pkg::gf_mul(i_cfg.coeff[k], i_data.r[k][p],
                                                    i_cfg.taps);
                end else begin
                    n_prod[k][p] = '0;
                end
            end
        end
    end

    always_comb begin
        n_value = '0;
        n_deriv = '0;
        for (int k = 0; k < gfpe_pkg::MAX_TERMS; k++) begin
            n_value = n_value ^ r_prod[k][0];
            n_deriv = n_deriv ^ r_prod[k][0] ^ r_prod[k][1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else if (i_en) begin
            r_prod_valid <= i_valid;
            r_out_valid  <= r_prod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= n_prod;
            r_value <= n_value;
            r_deriv <= n_deriv;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_value;
    assign o_deriv = r_deriv;

endmodule

>>> sim/tb_gf2n_poly_eval_derivative_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gf2n_poly_eval_derivative_core
// self-checking bench for the sparse GF(2^n) polynomial evaluator: corner and
// random field points are streamed in under a series of register settings,
// and every output beat is compared with an in-bench evaluation of F(x) and
// F(x) xor F(x xor a) under the settings of the current phase
// ----------------------------------------------------------------------------
module tb_gf2n_poly_eval_derivative_core;

    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 8;
    localparam int MAX_IDLE         = 10;
    localparam int LONG_HOLD        = 300;
    localparam int DRAIN_CYCLES     = 40;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int RANDOM_PHASES    = 13;
    localparam int POINTS_PER_PHASE = 100;

    typedef struct packed {
        gfpe_pkg::t_elem diff;
        gfpe_pkg::t_elem point;
    } t_eval_request;

    typedef struct packed {
        gfpe_pkg::t_elem value;
        gfpe_pkg::t_elem slope;
    } t_eval_result;

    logic                                s_axis_tvalid = 1'b0;
    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                s_axis_tready;
    logic [gfpe_pkg::DATA_BITS-1:0]      s_axis_tdata  = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [gfpe_pkg::DATA_BITS-1:0]      m_axis_tdata;
    logic                                i_cfg_valid   = 1'b0;
    logic                                o_cfg_ready;
    logic [gfpe_pkg::CFG_IDX_BITS-1:0]   i_cfg_index   = '0;
    logic [gfpe_pkg::CFG_DATA_BITS-1:0]  i_cfg_data    = '0;

    gf2n_poly_eval_derivative_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // bench copy of the register file, updated as each write is accepted
    logic [gfpe_pkg::MOD_BITS-1:0] cfg_modulus = gfpe_pkg::MODULUS_RESET;
    logic [gfpe_pkg::CNT_BITS-1:0] cfg_terms   = '0;
    gfpe_pkg::t_elem cfg_coeff [gfpe_pkg::MAX_TERMS] = '{default: '0};
    gfpe_pkg::t_pow  cfg_power [gfpe_pkg::MAX_TERMS] = '{default: '0};

    t_eval_request pending_requests [$];
    t_eval_result  expected_evals [$];

    int  queued_points   = 0;
    int  accepted_points = 0;
    int  beats_checked   = 0;
    int  mismatches      = 0;
    int  reg_writes      = 0;
    int  settings_used   = 0;
    int  input_stalls    = 0;
    int  send_wait       = 0;
    int  recv_wait       = 0;
    int  hold_left       = 0;
    bit  send_burst      = 1'b0;
    bit  recv_burst      = 1'b0;
    bit  hold_req        = 1'b0;
    bit  hold_taken      = 1'b0;

    // product modulo the configured polynomial, multiplier scanned top bit first
    function automatic gfpe_pkg::t_elem field_product(gfpe_pkg::t_elem a,
                                                      gfpe_pkg::t_elem b);
        gfpe_pkg::t_elem acc;
        gfpe_pkg::t_elem taps;
        taps = cfg_modulus[gfpe_pkg::FIELD_BITS-1:0];
        acc  = '0;
        for (int i = gfpe_pkg::FIELD_BITS - 1; i >= 0; i--) begin
            acc = {acc[gfpe_pkg::FIELD_BITS-2:0], 1'b0}
                ^ (acc[gfpe_pkg::FIELD_BITS-1] ? taps : '0);
            if (b[i]) begin
                acc = acc ^ a;
            end
        end
        return acc;
    endfunction

    // exponent scanned from the bottom; x^0 stays 1 even for x = 0
    function automatic gfpe_pkg::t_elem field_power(gfpe_pkg::t_elem x,
                                                    gfpe_pkg::t_pow e);
        gfpe_pkg::t_elem acc;
        gfpe_pkg::t_elem base;
        acc  = gfpe_pkg::t_elem'(1);
        base = x;
        for (int i = 0; i < gfpe_pkg::POW_BITS; i++) begin
            if (e[i]) begin
                acc = field_product(acc, base);
            end
            base = field_product(base, base);
        end
        return acc;
    endfunction

    function automatic gfpe_pkg::t_elem poly_at(gfpe_pkg::t_elem x);
        gfpe_pkg::t_elem sum;
        int              live;
        sum  = '0;
        live = (int'(cfg_terms) > gfpe_pkg::MAX_TERMS) ? gfpe_pkg::MAX_TERMS
                                                       : int'(cfg_terms);
        for (int k = 0; k < live; k++) begin
            sum = sum ^ field_product(cfg_coeff[k], field_power(x, cfg_power[k]));
        end
        return sum;
    endfunction

    function automatic t_eval_result evaluate_point(t_eval_request req);
        t_eval_result r;
        r.value = poly_at(req.point);
        r.slope = r.value ^ poly_at(req.point ^ req.diff);
        return r;
    endfunction

    task automatic flag_mismatch(string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // input driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_eval_request req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                req.point = s_axis_tdata[gfpe_pkg::FIELD_BITS-1:0];
                req.diff  = s_axis_tdata[2*gfpe_pkg::FIELD_BITS-1:gfpe_pkg::FIELD_BITS];
                expected_evals.push_back(evaluate_point(req));
                accepted_points++;
                send_wait = send_burst ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // beat held while the block pushes back
                input_stalls++;
            end else if (send_wait > 0) begin
                send_wait--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                req = pending_requests.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {req.diff, req.point};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // output monitor and ready generator
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_eval_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_wait = 0;
            hold_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                beats_checked++;
                if (expected_evals.size() == 0) begin
                    flag_mismatch($sformatf("beat %0d arrived with nothing pending, data %h",
                                            beats_checked, m_axis_tdata));
                end else begin
                    want = expected_evals.pop_front();
                    if (m_axis_tdata[gfpe_pkg::FIELD_BITS-1:0] !== want.value) begin
                        flag_mismatch($sformatf("beat %0d value_at_point %h, want %h",
                                                beats_checked,
                                                m_axis_tdata[gfpe_pkg::FIELD_BITS-1:0],
                                                want.value));
                    end
                    if (m_axis_tdata[2*gfpe_pkg::FIELD_BITS-1:gfpe_pkg::FIELD_BITS]
                        !== want.slope) begin
                        flag_mismatch($sformatf("beat %0d derivative_value %h, want %h",
                                                beats_checked,
                                                m_axis_tdata[2*gfpe_pkg::FIELD_BITS-1:
                                                             gfpe_pkg::FIELD_BITS],
                                                want.slope));
                    end
                end
                recv_wait = recv_burst ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: ends the run when no beat of any kind moves for too long
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // register writes and stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(gfpe_pkg::t_cfg_reg idx, int unsigned data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= gfpe_pkg::CFG_DATA_BITS'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            gfpe_pkg::CFG_FIELD_MODULUS: cfg_modulus  = gfpe_pkg::MOD_BITS'(data);
            gfpe_pkg::CFG_TERM_COUNT:    cfg_terms    = gfpe_pkg::CNT_BITS'(data);
            gfpe_pkg::CFG_COEFF_ZERO:    cfg_coeff[0] = gfpe_pkg::FIELD_BITS'(data);
            gfpe_pkg::CFG_POWER_ZERO:    cfg_power[0] = gfpe_pkg::POW_BITS'(data);
            gfpe_pkg::CFG_COEFF_ONE:     cfg_coeff[1] = gfpe_pkg::FIELD_BITS'(data);
            gfpe_pkg::CFG_POWER_ONE:     cfg_power[1] = gfpe_pkg::POW_BITS'(data);
            gfpe_pkg::CFG_COEFF_TWO:     cfg_coeff[2] = gfpe_pkg::FIELD_BITS'(data);
            gfpe_pkg::CFG_POWER_TWO:     cfg_power[2] = gfpe_pkg::POW_BITS'(data);
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic load_terms(int unsigned modulus, int unsigned terms,
                              int unsigned c0, int unsigned e0,
                              int unsigned c1, int unsigned e1,
                              int unsigned c2, int unsigned e2);
        write_reg(gfpe_pkg::CFG_FIELD_MODULUS, modulus);
        write_reg(gfpe_pkg::CFG_TERM_COUNT, terms);
        write_reg(gfpe_pkg::CFG_COEFF_ZERO, c0);
        write_reg(gfpe_pkg::CFG_POWER_ZERO, e0);
        write_reg(gfpe_pkg::CFG_COEFF_ONE, c1);
        write_reg(gfpe_pkg::CFG_POWER_ONE, e1);
        write_reg(gfpe_pkg::CFG_COEFF_TWO, c2);
        write_reg(gfpe_pkg::CFG_POWER_TWO, e2);
        settings_used++;
        @(negedge i_clk);
    endtask

    task automatic queue_point(int unsigned x, int unsigned a);
        t_eval_request req;
        req.point = gfpe_pkg::t_elem'(x);
        req.diff  = gfpe_pkg::t_elem'(a);
        pending_requests.push_back(req);
        queued_points++;
    endtask

    // block is idle once every queued point has gone in and come back out
    task automatic drain();
        while (accepted_points != queued_points || expected_evals.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    function automatic int unsigned pick_byte();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 255;
            2:       return 1;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic int unsigned pick_modulus();
        case ($urandom_range(0, 5))
            0:       return 283;
            1:       return 285;
            2:       return 256;
            3:       return 511;
            default: return $urandom_range(256, 511);
        endcase
    endfunction

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // registers at reset: no terms in use, every point gives zero
        queue_point(0, 0);
        queue_point(255, 255);
        queue_point(8'h53, 8'hca);
        drain();

        // unit coefficient at exponent zero, full coefficient at the top
        // exponent, and a live term with a zero coefficient
        load_terms(283, 3, 1, 0, 255, 255, 0, 7);
        queue_point(0, 0);
        queue_point(0, 255);
        queue_point(255, 0);
        queue_point(1, 1);
        queue_point(128, 127);
        queue_point(2, 83);
        queue_point(255, 255);
        drain();

        // no taps at all: reducible, high bits simply fall off
        load_terms(256, 1, 255, 2, 0, 0, 0, 0);
        queue_point(128, 1);
        queue_point(15, 240);
        queue_point(255, 0);
        drain();

        // every tap set, square plus cube
        load_terms(511, 2, 1, 2, 3, 3, 7, 9);
        queue_point(255, 128);
        queue_point(1, 254);
        queue_point(0, 1);
        drain();

        // count written to zero while coefficients are non-zero
        load_terms(285, 0, 255, 1, 255, 2, 255, 3);
        queue_point(7, 9);
        queue_point(255, 255);
        drain();

        // count of two leaves the third term out
        load_terms(283, 2, 0, 5, 1, 1, 255, 1);
        queue_point(3, 0);
        queue_point(200, 55);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            send_burst = (p % 4 == 1) || (p == 3) || (p == RANDOM_PHASES - 1);
            recv_burst = (p % 4 == 2) || (p == RANDOM_PHASES - 1);
            load_terms(pick_modulus(), $urandom_range(0, 3),
                       pick_byte(), pick_byte(), pick_byte(),
                       pick_byte(), pick_byte(), pick_byte());
            // long output stall with the input running flat out
            if (p == 3) begin
                hold_req = 1'b1;
            end
            repeat (POINTS_PER_PHASE) queue_point(pick_byte(), pick_byte());
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_evals.size() != 0) begin
            flag_mismatch($sformatf("%0d results never came out", expected_evals.size()));
        end

        $display("checked %0d output beats under %0d register settings (%0d register writes)",
                 beats_checked, settings_used, reg_writes);
        $display("input held off by back-pressure for %0d cycles, %0d mismatches",
                 input_stalls, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
